FILE: src/weighted_jacobi_stencil_smoother_defines.svh
// assertion macros for the stencil smoother checker
// no dependencies
`ifndef WEIGHTED_JACOBI_STENCIL_SMOOTHER_DEFINES_SVH
`define WEIGHTED_JACOBI_STENCIL_SMOOTHER_DEFINES_SVH

// clocked check, masked while reset is asserted
`define WJS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define WJS_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wjs_pkg.sv
// shared types and constants of the stencil smoother
// no dependencies
package wjs_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE = 3'd0,
        CFG_OMEGA     = 3'd1,
        CFG_SPACING   = 3'd2,
        CFG_BOUNDARY  = 3'd3,
        CFG_FACE_MASK = 3'd4
    } t_cfg_idx;

    // face mask bits
    localparam int FACE_Y_LO = 0;
    localparam int FACE_X_HI = 1;
    localparam int FACE_Y_HI = 2;
    localparam int FACE_X_LO = 3;
    localparam int FACE_Z_HI = 4;
    localparam int FACE_Z_LO = 5;

    // divide-by-six unit: biased dividend keeps it positive, then halve and
    // multiply by the reciprocal of three, (2^37 + 1) / 3, keeping bits 72..37
    localparam int                DIV_W     = 38;
    localparam int                QUO_W     = 36;
    localparam logic [DIV_W-1:0]  DIV_BIAS  = 38'h30_0000_0000;  // 6 * 2^35
    localparam logic [QUO_W-1:0]  DIV_UNB   = 36'h8_0000_0000;   // 2^35
    localparam logic [35:0]       DIV_RECIP = 36'hA_AAAA_AAAB;

    typedef struct packed {
        logic        [6:0]  grid_size;
        logic        [15:0] omega_weight;
        logic        [16:0] spacing_squared;
        logic signed [31:0] boundary_value;
        logic        [5:0]  face_mask;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] cval;
        logic signed [31:0] src;
        logic               region;   // inner cell, gives a result
        logic               bnd;      // takes the boundary value
        logic               last;
        logic               parity;   // plane parity of this cell
    } t_item;

endpackage

FILE: src/wjs_ram.sv
// generic simple dual-port ram, registered read
// no dependencies
module wjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/wjs_queue.sv
// two-entry queue between front and back end
// no dependencies
module wjs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_ent [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            if (i_push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
        if (i_push) r_ent[r_wr] <= i_data;
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_ent[r_rd];
endmodule

FILE: src/wjs_front.sv
// front end: raster counters and cell classification
// uses wjs_pkg
module wjs_front
    import wjs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int STRIDE     = MAX_POINTS + 4,
    parameter int SW         = $clog2(STRIDE * STRIDE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_accept,
    input  logic signed [31:0] i_cell_value,
    input  logic signed [31:0] i_source_value,
    output t_item              o_item,
    output logic [SW-1:0]      o_base
);
    localparam int CW = $clog2(STRIDE + 1);

    logic [CW-1:0] r_col, r_row, r_pln;
    logic [CW-1:0] n_eff, n_p2, n_p3, n_p4;
    logic          in_x, in_y, in_z;
    logic [5:0]    hit;

    always_comb begin
        if (i_cfg.grid_size == 7'd0) n_eff = CW'(1);
        else if (int'(i_cfg.grid_size) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
        else n_eff = CW'(i_cfg.grid_size);
        n_p2 = n_eff + CW'(2);
        n_p3 = n_eff + CW'(3);
        n_p4 = n_eff + CW'(4);
    end

    always_comb begin
        in_x = (r_col >= CW'(1)) && (r_col <= n_p2);
        in_y = (r_row >= CW'(1)) && (r_row <= n_p2);
        in_z = (r_pln >= CW'(2)) && (r_pln <= n_p3);
        hit[FACE_Y_LO] = (r_row == CW'(1));
        hit[FACE_X_HI] = (r_col == n_p2);
        hit[FACE_Y_HI] = (r_row == n_p2);
        hit[FACE_X_LO] = (r_col == CW'(1));
        hit[FACE_Z_HI] = (r_pln == n_p3);
        hit[FACE_Z_LO] = (r_pln == CW'(2));
        o_item.cval   = i_cell_value;
        o_item.src    = i_source_value;
        o_item.region = in_x && in_y && in_z;
        o_item.bnd    = |(hit & i_cfg.face_mask);
        o_item.last   = hit[FACE_X_HI] && hit[FACE_Y_HI] && hit[FACE_Z_HI];
        o_item.parity = r_pln[0];
        o_base        = SW'(r_row * STRIDE) + SW'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_pln <= '0;
        end else if (i_accept) begin
            if (r_col + CW'(1) >= n_p4) begin
                r_col <= '0;
                if (r_row + CW'(1) >= n_p4) begin
                    r_row <= '0;
                    if (r_pln + CW'(1) >= n_p4) r_pln <= '0;
                    else r_pln <= r_pln + CW'(1);
                end else begin
                    r_row <= r_row + CW'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end
endmodule

FILE: src/wjs_back.sv
// back end: plane buffers, stencil sum, divide by six, relaxation, output register
// uses wjs_pkg and wjs_ram
module wjs_back
    import wjs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int STRIDE     = MAX_POINTS + 4,
    parameter int SW         = $clog2(STRIDE * STRIDE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    input  logic [SW-1:0]      i_q_base,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_new_value,
    output logic               o_last_cell
);
    localparam int PLANE = STRIDE * STRIDE;
    localparam int PD    = 2 * PLANE;
    localparam int PW    = $clog2(PD);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_WRITE = 10'b0000000100,
        S_PREP  = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_QUO   = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_SUM   = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_HOLD  = 10'b1000000000
    } t_state;

    t_state              r_state;
    t_item               r_item;
    logic [SW-1:0]       r_base;
    logic [2:0]          r_cnt;
    logic signed [31:0]  r_u, r_src;
    logic signed [34:0]  r_sum;
    logic signed [49:0]  r_prod;
    logic [DIV_W-1:0]    r_div;
    logic [53:0]         r_pl;
    logic [54:0]         r_ph;
    logic [QUO_W-1:0]    r_quo;
    logic signed [48:0]  r_p1;
    logic signed [50:0]  r_p2;
    logic signed [31:0]  r_res;
    logic                r_out_valid, r_out_last;
    logic signed [31:0]  r_out_value;

    logic [SW-1:0]       rd_off;
    logic [PW-1:0]       p_raddr, p_waddr;
    logic signed [31:0]  p_rdata, s_rdata;
    logic                wr_en;
    logic signed [53:0]  num;
    logic [72:0]         recip;
    logic [QUO_W-1:0]    quot;
    logic signed [33:0]  v;
    logic signed [16:0]  w_keep, w_new;
    logic signed [51:0]  acc;
    logic signed [36:0]  scaled;
    logic                out_free;
    logic                out_load;

    // read order: center, x-1, x+1, y-1, y+1 of the middle plane, then lower plane
    always_comb begin
        case (r_cnt)
            3'd1:    rd_off = r_base - SW'(1);
            3'd2:    rd_off = r_base + SW'(1);
            3'd3:    rd_off = r_base - SW'(STRIDE);
            3'd4:    rd_off = r_base + SW'(STRIDE);
            default: rd_off = r_base;
        endcase
        if ((r_cnt == 3'd5) ? r_item.parity : ~r_item.parity)
            p_raddr = PW'(rd_off) + PW'(PLANE);
        else
            p_raddr = PW'(rd_off);
        p_waddr = r_item.parity ? PW'(r_base) + PW'(PLANE) : PW'(r_base);
    end

    assign wr_en = (r_state == S_WRITE);

    wjs_ram #(.WIDTH(32), .DEPTH(PD)) u_plane (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (p_waddr),
        .i_wdata (r_item.cval),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    wjs_ram #(.WIDTH(32), .DEPTH(PLANE)) u_source (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_base),
        .i_wdata (r_item.src),
        .i_raddr (r_base),
        .o_rdata (s_rdata)
    );

    always_comb begin
        num    = 54'(r_prod) + (54'(r_sum) <<< 16) + 54'sd196608;
        recip  = {r_ph, 18'd0} + 73'(r_pl);
        quot   = r_quo - DIV_UNB;
        v      = quot[33:0];
        w_new  = $signed({1'b0, i_cfg.omega_weight});
        w_keep = 17'sd32768 - w_new;
        acc    = 52'(r_p1) + 52'(r_p2) + 52'sd16384;
        scaled = acc[51:15];
        out_free = !r_out_valid || i_out_ready;
        out_load = (r_state == S_OUT || r_state == S_HOLD) && out_free;
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cnt   <= 3'd0;
                        r_state <= (i_q_item.region && !i_q_item.bnd) ? S_READ : S_WRITE;
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd6) r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (!r_item.region) r_state <= S_IDLE;
                    else if (r_item.bnd) r_state <= S_HOLD;
                    else r_state <= S_PREP;
                end
                S_PREP: r_state <= S_DIV;
                S_DIV:  r_state <= S_QUO;
                S_QUO:  r_state <= S_MUL;
                S_MUL:  r_state <= S_SUM;
                S_SUM:  r_state <= S_OUT;
                S_OUT, S_HOLD: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end

        // datapath
        case (r_state)
            S_IDLE: begin
                r_item <= i_q_item;
                r_base <= i_q_base;
                r_sum  <= 35'(i_q_item.cval);
            end
            S_READ: begin
                if (r_cnt == 3'd1) begin
                    r_u   <= p_rdata;
                    r_src <= s_rdata;
                end else if (r_cnt != 3'd0) begin
                    r_sum <= r_sum + 35'(p_rdata);
                end
            end
            S_WRITE: r_prod <= $signed({1'b0, i_cfg.spacing_squared}) * r_src;
            S_PREP:  r_div  <= num[53:16] + DIV_BIAS;
            // halved dividend times the reciprocal of three, in two halves
            S_DIV: begin
                r_pl <= 54'(r_div[18:1]) * 54'(DIV_RECIP);
                r_ph <= 55'(r_div[37:19]) * 55'(DIV_RECIP);
            end
            S_QUO: r_quo <= recip[72:37];
            S_MUL: begin
                r_p1 <= w_keep * r_u;
                r_p2 <= w_new * v;
            end
            S_SUM: begin
                if (scaled > 37'sd2147483647) r_res <= 32'sh7fffffff;
                else if (scaled < -37'sd2147483648) r_res <= 32'sh80000000;
                else r_res <= scaled[31:0];
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_value <= (r_state == S_HOLD) ? i_cfg.boundary_value : r_res;
            r_out_last  <= r_item.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_value = r_out_value;
    assign o_last_cell = r_out_last;
endmodule

FILE: src/weighted_jacobi_stencil_smoother.sv
// weighted jacobi 7-point stencil smoother, top level
// uses wjs_pkg, wjs_front, wjs_queue, wjs_back
//
// takes an (N+4)^3 grid in raster order (x fastest), one cell value and source
// term per beat, and returns one relaxed value per inner (N+2)^3 cell, in raster
// order, as soon as the cell above it has arrived. cells on faces flagged in
// face_mask return boundary_value. the front end tracks the raster position and
// tags each beat; a two-entry queue feeds the back end, which holds two planes of
// cell values and one plane of source terms in block ram. the back end works on
// one cell at a time: a halo cell goes through queue pop and plane write, a
// boundary cell through queue pop, plane write and output load, and a relaxed
// cell through queue pop, seven reads through the single plane ram read port,
// write, source product, sum alignment, a divide by six by reciprocal
// multiplication, the omega multiply, rounding and saturation, and output
// load. the result sits in an output register, so the next cell is worked on
// while a result waits. buffer contents are not cleared at reset: no cell is
// read before the sweep has written it. configuration is written through a
// plain write port and must only change while the block is idle.
module weighted_jacobi_stencil_smoother
    import wjs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [31:0]    i_cell_value,
    input  logic signed [31:0]    i_source_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_new_value,
    output logic                  o_last_cell
);
    localparam int STRIDE = MAX_POINTS + 4;
    localparam int SW     = $clog2(STRIDE * STRIDE);
    localparam int IW     = $bits(t_item);
    localparam int QW     = IW + SW;

    t_cfg          r_cfg;
    t_item         f_item, q_item;
    logic [SW-1:0] f_base, q_base;
    logic          accept, q_full, q_valid, q_pop;
    logic [QW-1:0] q_out;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_size       <= 7'd64;
            r_cfg.omega_weight    <= 16'd32768;
            r_cfg.spacing_squared <= 17'd15;
            r_cfg.boundary_value  <= 32'sd0;
            r_cfg.face_mask       <= 6'h3f;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_SIZE: r_cfg.grid_size       <= i_cfg_data[6:0];
                CFG_OMEGA:     r_cfg.omega_weight    <= i_cfg_data[15:0];
                CFG_SPACING:   r_cfg.spacing_squared <= i_cfg_data[16:0];
                CFG_BOUNDARY:  r_cfg.boundary_value  <= $signed(i_cfg_data);
                CFG_FACE_MASK: r_cfg.face_mask       <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // a beat is taken whenever the queue has room
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    wjs_front #(.MAX_POINTS(MAX_POINTS), .STRIDE(STRIDE), .SW(SW)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_cell_value   (i_cell_value),
        .i_source_value (i_source_value),
        .o_item         (f_item),
        .o_base         (f_base)
    );

    wjs_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({f_base, f_item}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign q_item = q_out[IW-1:0];
    assign q_base = q_out[QW-1:IW];

    wjs_back #(.MAX_POINTS(MAX_POINTS), .STRIDE(STRIDE), .SW(SW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .i_q_base    (q_base),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_new_value (o_new_value),
        .o_last_cell (o_last_cell)
    );
endmodule

FILE: src/wjs_checker.sv
// port-level checks for the stencil smoother, bound to the top level
// uses wjs_pkg and weighted_jacobi_stencil_smoother_defines.svh
`include "weighted_jacobi_stencil_smoother_defines.svh"
module wjs_checker
    import wjs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic signed [31:0]    i_cell_value,
    input logic signed [31:0]    i_source_value,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [31:0]    o_new_value,
    input logic                  o_last_cell
);
    // a stalled result beat holds
    `WJS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_new_value) && $stable(o_last_cell), "result beat changed while stalled")
    // reset empties the output register and the queue
    `WJS_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `WJS_ASSERT_RST(a_rst_ready, i_clk, !i_rst_n |=> o_in_ready, "input not ready after reset")
    // one sweep has at least 27 cells, so two last beats never follow each other
    `WJS_ASSERT(a_last_once, i_clk, i_rst_n, o_out_valid && i_out_ready && o_last_cell |=> !(o_out_valid && o_last_cell), "last cell repeated")
endmodule

bind weighted_jacobi_stencil_smoother wjs_checker u_wjs_checker (.*);

FILE: test/weighted_jacobi_stencil_smoother_test.sv
// self-checking testbench for the weighted jacobi stencil smoother
// depends on wjs_pkg and weighted_jacobi_stencil_smoother, and through it on the files that the top level uses
// streams (N+4)^3 sweeps, predicts every inner cell, checks in order
`timescale 1ns / 100ps

module weighted_jacobi_stencil_smoother_test;
    import wjs_pkg::*;

    localparam int STRIDE      = MAX_POINTS_DEF + 4;
    localparam int PLANE_CELLS = STRIDE * STRIDE;
    localparam int SRC_DEPTH   = PLANE_CELLS + STRIDE + 1;
    localparam int SETTLE      = 80;
    localparam logic [CFG_IDX_W-1:0] UNUSED_IDX = 3'd5;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
    } cell_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic signed [31:0]    i_cell_value = '0;
    logic signed [31:0]    i_source_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [31:0]    o_new_value;
    logic                  o_last_cell;

    weighted_jacobi_stencil_smoother i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cell_value   (i_cell_value),
        .i_source_value (i_source_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_new_value    (o_new_value),
        .o_last_cell    (o_last_cell)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block: configuration, raster position and buffers
    logic [6:0]         grid_reg;
    logic [15:0]        omega_reg;
    logic [16:0]        spacing_reg;
    logic signed [31:0] boundary_reg;
    logic [5:0]         mask_reg;
    int                 col_pos, row_pos, plane_pos;
    logic signed [31:0] plane_mem [2*PLANE_CELLS];
    logic signed [31:0] src_mem [SRC_DEPTH];

    cell_result_t relaxed_q[$];
    int           error_count = 0;
    int           sent_cells  = 0;
    bit           calm_sender = 1'b0;   // no gaps on the input side
    bit           calm_sink   = 1'b0;   // no stalls on the output side

    // floor division, matches the rounding of the block
    function automatic longint floor_div(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint plane_at(input int par, input int x, input int y);
        return longint'(plane_mem[(par & 1) * PLANE_CELLS + y * STRIDE + x]);
    endfunction

    function automatic int grid_points();
        int n;
        n = grid_reg;
        if (n < 1) n = 1;
        if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
        return n;
    endfunction

    // advance the shadow by one accepted beat and queue its result, if any
    task automatic relax_cell(input logic signed [31:0] cv, input logic signed [31:0] sv);
        int           n, ex, ey, ez, i, j, k, mid;
        longint       src_old, u, ngh, num, v, w, acc, res;
        bit           bnd;
        cell_result_t r;
        n  = grid_points();
        ex = col_pos;
        ey = row_pos;
        ez = plane_pos;
        src_old = longint'(src_mem[ey * STRIDE + ex]);
        if (ex >= 1 && ex <= n + 2 && ey >= 1 && ey <= n + 2 && ez >= 2 && ez <= n + 3) begin
            i = ex - 1;
            j = ey - 1;
            k = ez - 2;
            mid = ez - 1;
            bnd = (mask_reg[FACE_Y_LO] && j == 0) || (mask_reg[FACE_X_HI] && i == n + 1) ||
                  (mask_reg[FACE_Y_HI] && j == n + 1) || (mask_reg[FACE_X_LO] && i == 0) ||
                  (mask_reg[FACE_Z_HI] && k == n + 1) || (mask_reg[FACE_Z_LO] && k == 0);
            if (bnd) begin
                res = longint'(boundary_reg);
            end else begin
                u   = plane_at(mid, ex, ey);
                ngh = plane_at(mid, ex - 1, ey) + plane_at(mid, ex + 1, ey)
                    + plane_at(mid, ex, ey - 1) + plane_at(mid, ex, ey + 1)
                    + plane_at(ez, ex, ey) + longint'(cv);
                num = longint'(spacing_reg) * src_old + ngh * 65536;
                v   = floor_div(num + 3 * 65536, 6 * 65536);
                w   = longint'(omega_reg);
                acc = (32768 - w) * u + w * v;
                res = floor_div(acc + 16384, 32768);
                if (res > 64'sd2147483647) res = 64'sd2147483647;
                if (res < -64'sd2147483648) res = -64'sd2147483648;
            end
            r.value = res[31:0];
            r.last  = (i == n + 1 && j == n + 1 && k == n + 1);
            relaxed_q.push_back(r);
        end
        plane_mem[(ez & 1) * PLANE_CELLS + ey * STRIDE + ex] = cv;
        src_mem[ey * STRIDE + ex] = sv;
        // counters wrap at the current extent, also after a lowered grid size
        col_pos++;
        if (col_pos >= n + 4) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= n + 4) begin
                row_pos = 0;
                plane_pos++;
                if (plane_pos >= n + 4) plane_pos = 0;
            end
        end
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_GRID_SIZE: grid_reg     = data[6:0];
            CFG_OMEGA:     omega_reg    = data[15:0];
            CFG_SPACING:   spacing_reg  = data[16:0];
            CFG_BOUNDARY:  boundary_reg = data;
            CFG_FACE_MASK: mask_reg     = data[5:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] n, input logic [31:0] om, input logic [31:0] hh,
                           input logic [31:0] bv, input logic [31:0] fm);
        write_reg(CFG_GRID_SIZE, n);
        write_reg(CFG_OMEGA, om);
        write_reg(CFG_SPACING, hh);
        write_reg(CFG_BOUNDARY, bv);
        write_reg(CFG_FACE_MASK, fm);
    endtask

    // send one beat; called and returns at a falling edge
    task automatic send_cell(input logic signed [31:0] cv, input logic signed [31:0] sv);
        int r;
        if (!calm_sender) begin
            r = $urandom_range(0, 99);
            if (r >= 97)      repeat ($urandom_range(10, 40)) @(negedge i_clk);
            else if (r >= 70) repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_cell_value   = cv;
        i_source_value = sv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        relax_cell(cv, sv);
        sent_cells++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // mixed-range value: full random, small, an extreme, or a multiple of 2^16
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
            2: case ($urandom_range(0, 3))
                   0: return 32'sh7fffffff;
                   1: return 32'sh80000000;
                   2: return 32'sh0;
                   default: return -32'sd1;
               endcase
            default: return $signed($urandom_range(0, 1023)) <<< 16;
        endcase
    endfunction

    task automatic stream_to_origin();
        send_cell(pick_value(), pick_value());
        while (col_pos != 0 || row_pos != 0 || plane_pos != 0)
            send_cell(pick_value(), pick_value());
    endtask

    // wait until every expected beat is out, then let the block settle
    task automatic drain();
        while (relaxed_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // grid size 0 acts as 1; extreme weights and values, all faces relaxed
    task automatic test_small_extremes();
        set_all(0, 65535, 65536, 32'h8000_0000, 0);
        write_reg(UNUSED_IDX, $urandom);   // unknown index is ignored
        calm_sender = 1'b1;
        for (int c = 0; c < 125; c++) begin
            case (c % 4)
                0: send_cell(32'sh7fffffff, 32'sh7fffffff);
                1: send_cell(32'sh80000000, 32'sh80000000);
                2: send_cell(32'sh7fffffff, 32'sh80000000);
                default: send_cell(-32'sd1, 32'sh0);
            endcase
        end
        calm_sender = 1'b0;
        drain();
    endtask

    // each face bit alone, then all of them, on a 1-point grid
    task automatic test_boundary_faces();
        for (int f = 0; f <= 6; f++) begin
            set_all(1, 0, 0, $urandom, (f == 6) ? 63 : (1 << f));
            stream_to_origin();
            drain();
        end
    endtask

    // grid size above the maximum acts as the maximum: three rows wrap at the
    // maximum extent, then the sweep is finished at the smallest grid
    task automatic test_largest_grid();
        set_all(127, 32768, 15, $urandom, 0);
        for (int c = 0; c < 3 * STRIDE; c++)
            send_cell(pick_value(), pick_value());
        drain();
        write_reg(CFG_GRID_SIZE, 1);
        while (col_pos != 0 || row_pos != 0 || plane_pos != 0)
            send_cell(pick_value(), pick_value());
        drain();
    endtask

    // sender holds off mid-sweep until every expected beat has come
    task automatic test_sender_pause();
        set_all(2, $urandom_range(0, 65535), $urandom_range(0, 65536), $urandom, 6'h2a);
        for (int c = 0; c < 150; c++) send_cell(pick_value(), pick_value());
        while (relaxed_q.size() != 0) @(negedge i_clk);
        while (col_pos != 0 || row_pos != 0 || plane_pos != 0)
            send_cell(pick_value(), pick_value());
        drain();
    endtask

    // full sweeps with random settings, mostly small grids
    task automatic test_random_sweeps();
        int start_count, n, r;
        start_count = sent_cells;
        while (sent_cells - start_count < 200) begin
            r = $urandom_range(0, 9);
            n = (r < 4) ? $urandom_range(0, 2) : (r < 9) ? 3 : 4;
            set_all(n, $urandom_range(0, 65535),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 65536),
                    $urandom, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 63));
            calm_sender = ($urandom_range(0, 4) == 0);
            calm_sink   = ($urandom_range(0, 4) == 0);
            stream_to_origin();
            drain();
        end
        calm_sender = 1'b0;
        calm_sink   = 1'b0;
    endtask

    // receiver: random stalls, mostly short runs with a few long ones
    int sink_hold = 0;
    always @(negedge i_clk) begin
        if (calm_sink) begin
            i_out_ready = 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 65) begin
                i_out_ready = 1'b1;
                sink_hold   = $urandom_range(0, 8);
            end else if (r < 95) begin
                i_out_ready = 1'b0;
                sink_hold   = $urandom_range(0, 3);
            end else begin
                i_out_ready = 1'b0;
                sink_hold   = $urandom_range(10, 40);
            end
        end
    end

    // compare each accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            cell_result_t exp_r;
            if (relaxed_q.size() == 0) begin
                $error("unexpected result beat: new_value %h last_cell %b",
                       o_new_value, o_last_cell);
                error_count++;
            end else begin
                exp_r = relaxed_q.pop_front();
                if (o_new_value !== exp_r.value) begin
                    $error("new_value: expected %h actual %h", exp_r.value, o_new_value);
                    error_count++;
                end
                if (o_last_cell !== exp_r.last) begin
                    $error("last_cell: expected %b actual %b", exp_r.last, o_last_cell);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("weighted_jacobi_stencil_smoother_test: errors");
        $finish;
    end

    initial begin
        grid_reg     = 7'd64;
        omega_reg    = 16'd32768;
        spacing_reg  = 17'd15;
        boundary_reg = '0;
        mask_reg     = 6'h3f;
        col_pos      = 0;
        row_pos      = 0;
        plane_pos    = 0;
        foreach (plane_mem[a]) plane_mem[a] = '0;
        foreach (src_mem[a]) src_mem[a] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_small_extremes();
        test_boundary_faces();
        test_largest_grid();
        test_sender_pause();
        test_random_sweeps();

        drain();
        if (error_count == 0 && relaxed_q.size() == 0) begin
            $display("weighted_jacobi_stencil_smoother_test: clean");
        end else begin
            $display("weighted_jacobi_stencil_smoother_test: errors");
        end
        $finish;
    end

endmodule
